// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the summarizer project.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ees_pkg.sv =====
// Shared widths, codes, types and arithmetic helpers of the event energy summarizer.
// Depends on nothing; imported by the channel interfaces and the core.
package ees_pkg;

    // Accumulator width; energy sums saturate at 2^ACC_WIDTH - 1
    localparam int ACC_WIDTH = 32;

    localparam int CMD_W    = 1;
    localparam int EVENT_W  = 32;
    localparam int PRIM_W   = 4;
    localparam int LAYER_W  = 3;
    localparam int ENERGY_W = 24;
    localparam int OUT_W    = 32;
    localparam int THR_W    = 32;
    localparam int CMP_W    = (ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W;

    // Register file: 32-bit registers by word address; only word 0 holds a register
    localparam int REG_ADDR_W = 3;
    localparam int REG_DATA_W = 32;
    localparam logic [REG_ADDR_W-3:0] REG_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 32'd26214;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_HIT   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 1'b1;

    // Tracked primaries and summed layers
    localparam logic [PRIM_W-1:0]  PRIM_FIRST  = 4'd1;
    localparam logic [PRIM_W-1:0]  PRIM_SECOND = 4'd2;
    localparam logic [LAYER_W-1:0] LAYER_ZERO  = 3'd0;
    localparam logic [LAYER_W-1:0] LAYER_ONE   = 3'd1;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    typedef logic [ACC_WIDTH-1:0] acc_t;

    // Running sums of one primary within the open event group
    typedef struct packed {
        logic               seen;
        logic [LAYER_W-1:0] start_layer;
        acc_t               total;
        acc_t               layer0;
        acc_t               layer1;
    } prim_acc_t;

    localparam prim_acc_t PRIM_ACC_CLEAR = '0;

    // Add an energy deposit, sticking at the accumulator maximum
    function automatic acc_t sat_add(acc_t acc, logic [ENERGY_W-1:0] energy);
        logic [ACC_WIDTH:0] sum;
        sum = {1'b0, acc} + (ACC_WIDTH+1)'(energy);
        return sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : sum[ACC_WIDTH-1:0];
    endfunction

    // Clip an accumulator to the output width
    function automatic logic [OUT_W-1:0] clip_out(acc_t acc);
        logic [CMP_W-1:0] v;
        v = CMP_W'(acc);
        return (v > CMP_W'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
    endfunction

    // Strict compare of a full accumulator against the threshold
    function automatic logic above_threshold(acc_t acc, logic [THR_W-1:0] thr);
        logic [CMP_W-1:0] a;
        logic [CMP_W-1:0] t;
        a = CMP_W'(acc);
        t = CMP_W'(thr);
        return a > t;
    endfunction

    // Fold one hit into the sums of its primary
    function automatic prim_acc_t prim_update(prim_acc_t cur, logic [LAYER_W-1:0] layer,
                                              logic [ENERGY_W-1:0] energy);
        prim_acc_t res;
        res = cur;
        if (!cur.seen)
        begin
            res.start_layer = layer;
        end
        res.seen  = 1'b1;
        res.total = sat_add(cur.total, energy);
        if (layer == LAYER_ZERO)
        begin
            res.layer0 = sat_add(cur.layer0, energy);
        end
        else if (layer == LAYER_ONE)
        begin
            res.layer1 = sat_add(cur.layer1, energy);
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/ees_channels.sv =====
// Valid/ready channel interfaces for hit words in and summary words out.
// Depends on ees_pkg for field widths.
interface ees_hit_if import ees_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [EVENT_W-1:0]  event_number;
    logic [PRIM_W-1:0]   primary_number;
    logic [LAYER_W-1:0]  layer_number;
    logic [ENERGY_W-1:0] deposit_energy;

    modport source (
        output valid, cmd, event_number, primary_number, layer_number, deposit_energy,
        input  ready
    );
    modport sink (
        input  valid, cmd, event_number, primary_number, layer_number, deposit_energy,
        output ready
    );
endinterface

interface ees_sum_if import ees_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] summary_event;
    logic [OUT_W-1:0]   total_first;
    logic [LAYER_W-1:0] start_layer_first;
    logic [OUT_W-1:0]   layer0_first;
    logic [OUT_W-1:0]   layer1_first;
    logic [OUT_W-1:0]   total_second;
    logic [LAYER_W-1:0] start_layer_second;
    logic [OUT_W-1:0]   layer0_second;
    logic [OUT_W-1:0]   layer1_second;
    logic               coincidence;

    modport source (
        output valid, summary_event, total_first, start_layer_first, layer0_first,
               layer1_first, total_second, start_layer_second, layer0_second,
               layer1_second, coincidence,
        input  ready
    );
    modport sink (
        input  valid, summary_event, total_first, start_layer_first, layer0_first,
               layer1_first, total_second, start_layer_second, layer0_second,
               layer1_second, coincidence,
        output ready
    );
endinterface

// ===== rtl/core/event_energy_summarizer_core.sv =====
// Event energy summarizer: groups hit words by event number and emits one summary
// word per closed group that saw both primaries. One word per clock is accepted;
// a word passes an input register, then the accumulate/close logic loads the group
// state and the summary register; a summary is registered as the hit or flush that
// closes its group leaves the input register. Input stalls only while a finished
// summary waits in the summary register and the sink holds ready low. Threshold
// register at byte 0 over an APB-style port, reset value 26214 (0.4 MeV in units
// of 2^-16 MeV). Depends on ees_pkg and the channel interfaces in ees_channels.sv.
module event_energy_summarizer_core
    import ees_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ees_hit_if.sink               hit_in,
    ees_sum_if.source             sum_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [REG_DATA_W-1:0] pwdata,
    output logic [REG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Input register
    logic                in_valid_reg;
    logic [CMD_W-1:0]    in_cmd_reg;
    logic [EVENT_W-1:0]  in_event_reg;
    logic [PRIM_W-1:0]   in_prim_reg;
    logic [LAYER_W-1:0]  in_layer_reg;
    logic [ENERGY_W-1:0] in_energy_reg;

    // Group state
    logic               group_open_reg, group_open_next;
    logic [EVENT_W-1:0] group_event_reg, group_event_next;
    prim_acc_t          first_reg, first_next;
    prim_acc_t          second_reg, second_next;
    logic [THR_W-1:0]   threshold_reg;

    // Summary register
    logic               out_valid_reg;
    logic [EVENT_W-1:0] out_event_reg;
    logic [OUT_W-1:0]   out_total_first_reg, out_layer0_first_reg, out_layer1_first_reg;
    logic [OUT_W-1:0]   out_total_second_reg, out_layer0_second_reg, out_layer1_second_reg;
    logic [LAYER_W-1:0] out_start_first_reg, out_start_second_reg;
    logic               out_coinc_reg;

    logic      is_flush;
    logic      close_group;
    logic      emit;
    logic      advance;
    logic      cfg_write;
    prim_acc_t base_first, base_second;

    // Close and emit decisions for the word in the input register
    assign is_flush    = (in_cmd_reg == CMD_FLUSH);
    assign close_group = group_open_reg && (is_flush || (in_event_reg != group_event_reg));
    assign emit        = close_group && first_reg.seen && second_reg.seen;
    assign advance     = in_valid_reg && (!emit || !out_valid_reg || sum_out.ready);

    assign hit_in.ready = !in_valid_reg || advance;

    // Next group state: clear on close, then fold in a hit
    always_comb
    begin
        base_first  = close_group ? PRIM_ACC_CLEAR : first_reg;
        base_second = close_group ? PRIM_ACC_CLEAR : second_reg;
        first_next  = base_first;
        second_next = base_second;
        if (is_flush)
        begin
            group_open_next  = 1'b0;
            group_event_next = '0;
        end
        else
        begin
            group_open_next  = 1'b1;
            group_event_next = in_event_reg;
            if (in_prim_reg == PRIM_FIRST)
            begin
                first_next = prim_update(base_first, in_layer_reg, in_energy_reg);
            end
            else if (in_prim_reg == PRIM_SECOND)
            begin
                second_next = prim_update(base_second, in_layer_reg, in_energy_reg);
            end
        end
    end

    // Capture a hit word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (hit_in.ready)
        begin
            in_valid_reg <= hit_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_in.valid && hit_in.ready)
        begin
            in_cmd_reg    <= hit_in.cmd;
            in_event_reg  <= hit_in.event_number;
            in_prim_reg   <= hit_in.primary_number;
            in_layer_reg  <= hit_in.layer_number;
            in_energy_reg <= hit_in.deposit_energy;
        end
    end

    // Advance group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_open_reg  <= 1'b0;
            group_event_reg <= '0;
            first_reg       <= PRIM_ACC_CLEAR;
            second_reg      <= PRIM_ACC_CLEAR;
        end
        else if (advance)
        begin
            group_open_reg  <= group_open_next;
            group_event_reg <= group_event_next;
            first_reg       <= first_next;
            second_reg      <= second_next;
        end
    end

    // Summary word handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sum_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Load summary payload from the closing group
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_event_reg         <= group_event_reg;
            out_total_first_reg   <= clip_out(first_reg.total);
            out_start_first_reg   <= first_reg.start_layer;
            out_layer0_first_reg  <= clip_out(first_reg.layer0);
            out_layer1_first_reg  <= clip_out(first_reg.layer1);
            out_total_second_reg  <= clip_out(second_reg.total);
            out_start_second_reg  <= second_reg.start_layer;
            out_layer0_second_reg <= clip_out(second_reg.layer0);
            out_layer1_second_reg <= clip_out(second_reg.layer1);
            out_coinc_reg         <= above_threshold(first_reg.total, threshold_reg) &&
                                     above_threshold(second_reg.total, threshold_reg);
        end
    end

    assign sum_out.valid              = out_valid_reg;
    assign sum_out.summary_event      = out_event_reg;
    assign sum_out.total_first        = out_total_first_reg;
    assign sum_out.start_layer_first  = out_start_first_reg;
    assign sum_out.layer0_first       = out_layer0_first_reg;
    assign sum_out.layer1_first       = out_layer1_first_reg;
    assign sum_out.total_second       = out_total_second_reg;
    assign sum_out.start_layer_second = out_start_second_reg;
    assign sum_out.layer0_second      = out_layer0_second_reg;
    assign sum_out.layer1_second      = out_layer1_second_reg;
    assign sum_out.coincidence        = out_coinc_reg;

    // Register port: write on the access cycle
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[REG_ADDR_W-1:2])
                REG_THRESHOLD: threshold_reg <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read decode
    always_comb
    begin
        unique case (paddr[REG_ADDR_W-1:2])
            REG_THRESHOLD: prdata = REG_DATA_W'(threshold_reg);
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/ees_checker.sv =====
// Port-level checks on the summary channel of the event energy summarizer.
// Depends on ees_pkg and assert_macros.svh; bound to the core below.
`include "assert_macros.svh"

module ees_checker
    import ees_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               sum_valid,
    input logic               sum_ready,
    input logic [OUT_W-1:0]   total_first,
    input logic [OUT_W-1:0]   layer0_first,
    input logic [OUT_W-1:0]   layer1_first,
    input logic [OUT_W-1:0]   total_second,
    input logic [OUT_W-1:0]   layer0_second,
    input logic [OUT_W-1:0]   layer1_second,
    input logic               coincidence
);

    // Keep a stalled summary word valid
    `ASSERT_NEXT(a_sum_hold, clk, rst_n, sum_valid && !sum_ready, sum_valid, "summary dropped while stalled")

    // Layer sums never exceed the primary total
    `ASSERT_SAME(a_layers_first, clk, rst_n, sum_valid, (layer0_first <= total_first) && (layer1_first <= total_first), "first primary layer sum above total")
    `ASSERT_SAME(a_layers_second, clk, rst_n, sum_valid, (layer0_second <= total_second) && (layer1_second <= total_second), "second primary layer sum above total")

    // Coincidence needs energy from both primaries
    `ASSERT_SAME(a_coinc_energy, clk, rst_n, sum_valid && coincidence, (total_first != '0) && (total_second != '0), "coincidence with an empty total")

endmodule

bind event_energy_summarizer_core ees_checker u_ees_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .sum_valid     (sum_out.valid),
    .sum_ready     (sum_out.ready),
    .total_first   (sum_out.total_first),
    .layer0_first  (sum_out.layer0_first),
    .layer1_first  (sum_out.layer1_first),
    .total_second  (sum_out.total_second),
    .layer0_second (sum_out.layer0_second),
    .layer1_second (sum_out.layer1_second),
    .coincidence   (sum_out.coincidence)
);
